FILE: hw/rtl/decimal_print_with_point_defines.svh
// assertion macros for the decimal printer
`ifndef DECIMAL_PRINT_WITH_POINT_DEFINES_SVH
`define DECIMAL_PRINT_WITH_POINT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define DPP_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("check failed");

// next-cycle implication, clocked on clk, off during reset
`define DPP_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("check failed");

`endif

FILE: hw/rtl/dpp_pkg.sv
// types, constants and helpers shared by the decimal printer
`timescale 1ns / 1ps
package dpp_pkg;

  localparam int MAX_DIGITS  = 10;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 4;
  localparam int CHAR_W      = 7;
  localparam int BCD_W       = 4 * MAX_DIGITS;
  localparam int CONV_STEPS  = VALUE_W;
  localparam int STEP_W      = $clog2(CONV_STEPS);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 7'h2e;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   dot;
    logic [POS_W-1:0]   need;
    logic               has_point;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // add three to every digit of five or more before the shift
  function automatic logic [BCD_W-1:0] dabble_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    res = bcd;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        res[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/dpp_item_if.sv
// input channel: number, point position and precision
`timescale 1ns / 1ps
interface dpp_item_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [3:0]  point_pos;
  logic [3:0]  precision;

  modport source (output valid, value, point_pos, precision, input ready);
  modport sink (input valid, value, point_pos, precision, output ready);
endinterface

FILE: hw/rtl/dpp_char_if.sv
// output channel: one ascii character per transfer
`timescale 1ns / 1ps
interface dpp_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_out;
  logic       last;

  modport source (output valid, char_out, last, input ready);
  modport sink (input valid, char_out, last, output ready);
endinterface

FILE: hw/rtl/dpp_front.sv
// front end: accepts numbers and classifies point and precision
`timescale 1ns / 1ps
module dpp_front #(
  parameter int DIGITS = 10
) (
  dpp_item_if.sink        item,
  input  dpp_pkg::q_status_t qs,
  output logic            push,
  output dpp_pkg::job_t   job
);
  import dpp_pkg::*;

  assign item.ready = !qs.full;
  assign push       = item.valid && !qs.full;

  always_comb begin
    job.value     = item.value;
    job.dot       = item.point_pos;
    job.need      = (item.precision == '0) ? POS_W'(1) : item.precision;
    job.has_point = item.point_pos < POS_W'(DIGITS);
  end
endmodule

FILE: hw/rtl/dpp_queue.sv
// short queue of classified jobs between front and back
`timescale 1ns / 1ps
module dpp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dpp_pkg::job_t      wr_job,
  input  logic               pop,
  output dpp_pkg::job_t      rd_job,
  output dpp_pkg::q_status_t qs
);
  import dpp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qs.full  = count == CNT_W'(QUEUE_DEPTH);
  assign qs.empty = count == '0;
  assign rd_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end
endmodule

FILE: hw/rtl/dpp_back.sv
// back end: shift-add-3 conversion, then character output
`timescale 1ns / 1ps
module dpp_back #(
  parameter int DIGITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  dpp_pkg::job_t      head,
  input  dpp_pkg::q_status_t qs,
  output logic               pop,
  dpp_char_if.source         chars
);
  import dpp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state;
  logic [STEP_W-1:0]  step;
  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   frac;
  logic               point_seen;
  logic [POS_W-1:0]   dot;
  logic [POS_W-1:0]   need;
  logic               has_point;
  logic               out_valid;
  logic [CHAR_W-1:0]  out_char;
  logic               out_last;

  logic             load;
  logic             dot_due;
  logic             stop;
  logic [3:0]       digit;
  logic [BCD_W-1:0] bcd_adj;

  assign pop     = (state == ST_IDLE) && !qs.empty;
  assign load    = (state == ST_EMIT) && (!out_valid || chars.ready);
  assign dot_due = has_point && !point_seen && (pos == dot);
  assign digit   = bcd[{pos, 2'b00} +: 4];
  assign stop    = (pos == '0) ||
                   (point_seen && ({1'b0, frac} + 5'd1 >= {1'b0, need}));
  assign bcd_adj = dabble_adjust(bcd);

  assign chars.valid    = out_valid;
  assign chars.char_out = out_char;
  assign chars.last     = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      pos        <= POS_W'(9);
      frac       <= '0;
      point_seen <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            state <= ST_CONV;
            step  <= '0;
          end
        end
        ST_CONV: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(CONV_STEPS - 1)) begin
            state      <= ST_EMIT;
            pos        <= POS_W'(DIGITS - 1);
            frac       <= '0;
            point_seen <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (load) begin
            if (dot_due) begin
              point_seen <= 1'b1;
            end else begin
              if (stop) begin
                state <= ST_IDLE;
              end else begin
                pos <= pos - POS_W'(1);
                if (point_seen) begin
                  frac <= frac + POS_W'(1);
                end
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      bin       <= head.value;
      bcd       <= '0;
      dot       <= head.dot;
      need      <= head.need;
      has_point <= head.has_point;
    end else if (state == ST_CONV) begin
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
      bin <= {bin[VALUE_W-2:0], 1'b0};
    end
    if (load) begin
      if (dot_due) begin
        out_char <= CHAR_POINT;
        out_last <= 1'b0;
      end else begin
        out_char <= CHAR_ZERO + CHAR_W'(digit);
        out_last <= stop;
      end
    end
  end
endmodule

FILE: hw/rtl/decimal_print_with_point.sv
// top level of the fixed-width decimal printer with point
//
//   channel  dir  transfer when      payload
//   item     in   valid && ready     value[31:0], point_pos[3:0], precision[3:0]
//   chars    out  valid && ready     char_out[6:0], last
//
// one number leaves the queue, passes through the shift-add-3 converter, then
// goes out one character at a time (up to DIGITS+1) through the output
// register; the back end finishes one number before it takes the next.
// the front takes up to two numbers into the queue while the back works.
// reset is synchronous and clears the queue, the sequencer and output valid.
// an output stall holds the sequencer; the front keeps filling the queue.
`timescale 1ns / 1ps
module decimal_print_with_point #(
  parameter int DIGITS = 10
) (
  input logic        clk,
  input logic        rst,
  dpp_item_if.sink   item,
  dpp_char_if.source chars
);
  import dpp_pkg::*;

  logic      push;
  logic      pop;
  job_t      wr_job;
  job_t      rd_job;
  q_status_t qs;

  dpp_front #(.DIGITS(DIGITS)) u_front (
    .item (item),
    .qs   (qs),
    .push (push),
    .job  (wr_job)
  );

  dpp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .qs     (qs)
  );

  dpp_back #(.DIGITS(DIGITS)) u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (rd_job),
    .qs    (qs),
    .pop   (pop),
    .chars (chars)
  );
endmodule

FILE: hw/rtl/dpp_checker.sv
// port-level checks on the character output, bound to the top level
`timescale 1ns / 1ps
`include "decimal_print_with_point_defines.svh"
module dpp_checker (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic [6:0] char_out,
  input logic       last
);
  import dpp_pkg::*;

  logic is_point;
  assign is_point = char_out == CHAR_POINT;

  `DPP_ASSERT_NEXT(a_hold, valid && !ready, valid && $stable(char_out) && $stable(last))
  `DPP_ASSERT_NOW(a_charset, valid, is_point || (char_out >= CHAR_ZERO && char_out <= 7'h39))
  `DPP_ASSERT_NOW(a_point_not_last, valid && is_point, !last)
  `DPP_ASSERT_NEXT(a_digit_after_point, valid && ready && is_point, !(valid && is_point))
endmodule

bind decimal_print_with_point dpp_checker u_dpp_checker (
  .clk      (clk),
  .rst      (rst),
  .valid    (chars.valid),
  .ready    (chars.ready),
  .char_out (chars.char_out),
  .last     (chars.last)
);
